// ----- hw/rtl/keystroke_report_pacing_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// Keystroke report pacing queue: assertion macros
// Shared property forms for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef KEYSTROKE_REPORT_PACING_QUEUE_TOP_DEFINES_SVH
`define KEYSTROKE_REPORT_PACING_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication
`define KPRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KPRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/kprq_pkg.sv -----
// ----------------------------------------------------------------------------
// kprq_pkg
// Types and fixed constants of the keystroke report pacing queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kprq_pkg;

  localparam int TIME_W  = 64;
  localparam int DELAY_W = 20;

  // HID codes that trigger the long pause
  localparam logic [7:0] KEY_ENTER    = 8'h28;
  localparam logic [7:0] KEY_R        = 8'h15;
  localparam logic [7:0] MOD_LEFT_GUI = 8'h08;

  localparam logic [DELAY_W-1:0] LONG_DELAY_RESET = 20'd150000;

  // Request kinds as seen on the input and in the command queue
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        modifier;
    logic [7:0]        keycode;
    logic [TIME_W-1:0] time_us;
  } item_t;

  typedef struct packed {
    logic [7:0] report_modifier;
    logic [7:0] report_keycode;
  } report_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic              op;
    report_t           entry;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kprq_front.sv -----
// ----------------------------------------------------------------------------
// kprq_front
// Accepts requests, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kprq_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire kprq_pkg::item_t item,
  output logic                cmd_valid,
  output kprq_pkg::cmd_t      cmd,
  input  wire logic           cmd_pop
);

  kprq_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  kprq_pkg::cmd_t classified;

  assign item_stall = (count == 2'd2);
  assign accept     = item_valid && !item_stall;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = slots[rd_ptr];

  // Classify: ticks carry only time, pushes only the key entry
  always_comb begin
    classified.op = item.kind;
    if (item.kind == kprq_pkg::KIND_TICK) begin
      classified.entry   = '0;
      classified.time_us = item.time_us;
    end else begin
      classified.entry.report_modifier = item.modifier;
      classified.entry.report_keycode  = item.keycode;
      classified.time_us               = '0;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= classified;
    end
  end

  // Queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (accept && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!accept && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kprq_back.sv -----
// ----------------------------------------------------------------------------
// kprq_back
// Entry ring memory, pacing check and report output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kprq_back #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          long_delay_we,
  input  wire logic [kprq_pkg::DELAY_W-1:0]  long_delay_wdata,
  input  wire logic                          cmd_valid,
  input  wire kprq_pkg::cmd_t                cmd,
  output logic                               cmd_pop,
  output logic                               report_valid,
  input  wire logic                          report_stall,
  output kprq_pkg::report_t                  report
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   USED_MAX  = (PTR_W+1)'(QUEUE_DEPTH - 3);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PUSH2 = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  kprq_pkg::report_t               mem [QUEUE_DEPTH];
  kprq_pkg::report_t               rd_data;
  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [PTR_W-1:0]                read_pointer;
  logic [PTR_W-1:0]                write_pointer;
  logic [PTR_W-1:0]                rd_ptr_inc;
  logic [PTR_W-1:0]                wr_ptr_inc;
  logic [kprq_pkg::TIME_W-1:0]     last_emit_time;
  logic                            long_wait_pending;
  logic [kprq_pkg::DELAY_W-1:0]    long_delay_us;
  logic [PTR_W:0]                  used;
  logic [kprq_pkg::TIME_W-1:0]     elapsed;
  logic [kprq_pkg::TIME_W-1:0]     delay;
  logic                            has_room;
  logic                            is_empty;
  logic                            is_due;
  logic                            out_free;
  logic                            mem_we;
  kprq_pkg::report_t               mem_wdata;
  logic                            rd_en;
  logic                            wr_adv;

  // Ring pointer increments with wrap at any depth
  assign rd_ptr_inc = (read_pointer == PTR_LAST) ? '0 : read_pointer + PTR_W'(1);
  assign wr_ptr_inc = (write_pointer == PTR_LAST) ? '0 : write_pointer + PTR_W'(1);

  // Fill level; a pair needs two free slots with one always left empty
  assign used = (write_pointer >= read_pointer)
              ? {1'b0, write_pointer} - {1'b0, read_pointer}
              : {1'b0, write_pointer} + DEPTH_EXT - {1'b0, read_pointer};
  assign has_room = (used <= USED_MAX);
  assign is_empty = (read_pointer == write_pointer);

  // Pacing check, time wraps modulo 2^64
  assign elapsed  = cmd.time_us - last_emit_time;
  assign delay    = long_wait_pending
                  ? {{(kprq_pkg::TIME_W-kprq_pkg::DELAY_W){1'b0}}, long_delay_us}
                  : '0;
  assign is_due   = (elapsed >= delay);
  assign out_free = !report_valid || !report_stall;

  // Sequencer decode
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = cmd.entry;
    rd_en      = 1'b0;
    wr_adv     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == kprq_pkg::KIND_PUSH) begin
            cmd_pop = 1'b1;
            if (has_room) begin
              mem_we     = 1'b1;
              wr_adv     = 1'b1;
              state_next = ST_PUSH2;
            end
          end else if (is_empty || !is_due) begin
            cmd_pop = 1'b1;
          end else if (out_free) begin
            cmd_pop    = 1'b1;
            rd_en      = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_PUSH2: begin
        // release entry follows the press
        mem_we     = 1'b1;
        mem_wdata  = '0;
        wr_adv     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_pointer] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[read_pointer];
    end
  end

  // Report payload
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      report <= rd_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      read_pointer      <= '0;
      write_pointer     <= '0;
      last_emit_time    <= '0;
      long_wait_pending <= 1'b0;
      long_delay_us     <= kprq_pkg::LONG_DELAY_RESET;
      report_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (long_delay_we) begin
        long_delay_us <= long_delay_wdata;
      end
      if (wr_adv) begin
        write_pointer <= wr_ptr_inc;
      end
      if (rd_en) begin
        read_pointer   <= rd_ptr_inc;
        last_emit_time <= cmd.time_us;
      end
      if (state == ST_READ) begin
        report_valid      <= 1'b1;
        long_wait_pending <= (rd_data.report_keycode == kprq_pkg::KEY_ENTER) ||
                             (rd_data.report_modifier == kprq_pkg::MOD_LEFT_GUI &&
                              rd_data.report_keycode == kprq_pkg::KEY_R);
      end else if (report_valid && !report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/keystroke_report_pacing_queue_top.sv -----
// Keystroke report pacing queue. Requests either push a key press with its
// all-zero release into a QUEUE_DEPTH-entry ring memory, or deliver the
// current microsecond time; a time request pops and reports the head entry
// once the pause since the last report has run out (long_delay_us after
// Enter or left GUI+R, none otherwise). A push that would leave fewer than
// one free slot is dropped. A two-request front queue takes requests while
// the back end works. In the back end a push makes two writes through the
// single memory write port, a time request that reports does a registered
// memory read and then loads the report register, and one that reports
// nothing only pops its request. A report waits in an output register; a
// reporting time request starts only when that register is free.
// ----------------------------------------------------------------------------
// keystroke_report_pacing_queue_top
// Front request queue, back pacing engine and configuration register port.
// ----------------------------------------------------------------------------
`default_nettype none

module keystroke_report_pacing_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         long_delay_we,
  input  wire logic [kprq_pkg::DELAY_W-1:0] long_delay_wdata,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire kprq_pkg::item_t              item,
  output logic                              report_valid,
  input  wire logic                         report_stall,
  output kprq_pkg::report_t                 report
);

  logic           cmd_valid;
  logic           cmd_pop;
  kprq_pkg::cmd_t cmd;

  // Request intake
  kprq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // Queue and pacing engine
  kprq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .long_delay_we    (long_delay_we),
    .long_delay_wdata (long_delay_wdata),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .report_valid     (report_valid),
    .report_stall     (report_stall),
    .report           (report)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/kprq_checker.sv -----
// ----------------------------------------------------------------------------
// kprq_checker
// Port-level checks of the keystroke report pacing queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keystroke_report_pacing_queue_top_defines.svh"

module kprq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_stall,
  input wire logic              report_valid,
  input wire logic              report_stall,
  input wire kprq_pkg::report_t report
);

  // A stalled report holds
  `KPRQ_ASSERT_NEXT(a_report_hold, report_valid && report_stall, report_valid && $stable(report), "report changed while stalled")

  // Out of reset: no report pending and front queue open
  `KPRQ_ASSERT_NOW(a_reset_clear, $fell(rst), !report_valid && !item_stall, "not clear after reset")

  // A report load follows a registered memory read, so reports never come back to back
  `KPRQ_ASSERT_NEXT(a_report_gap, report_valid && !report_stall, !report_valid, "report right after a taken report")

endmodule

bind keystroke_report_pacing_queue_top kprq_checker u_kprq_checker (.*);

`default_nettype wire

// ----- dv/kprq_report_checker.sv -----
// ----------------------------------------------------------------------------
// kprq_report_checker
// Watches the request, report and delay-register ports of the pacing queue,
// keeps its own copy of the queue and the pause state, and compares every
// accepted report in order against the reports it has worked out.
// ----------------------------------------------------------------------------

module kprq_report_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         long_delay_we,
  input  logic [kprq_pkg::DELAY_W-1:0] long_delay_wdata,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  kprq_pkg::item_t              item,
  input  logic                         report_valid,
  input  logic                         report_stall,
  input  kprq_pkg::report_t            report,
  output int                           fail_count,
  output int                           pending
);
  import kprq_pkg::*;

  localparam int MAX_SHOWN = 10;

  // Shadow queue and pacing state
  report_t           slot_mem [QUEUE_DEPTH];
  int                rd_slot;
  int                wr_slot;
  logic [TIME_W-1:0] last_report_time;
  logic              long_pause_armed;
  logic [DELAY_W-1:0] pause_len;
  report_t           due_reports [$];

  // Apply one accepted request to the shadow state
  task automatic pace_request(input item_t req);
    int                used;
    logic [TIME_W-1:0] hold;
    report_t           head;
    if (req.kind == KIND_PUSH) begin
      used = (wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH;
      // one slot always stays empty; the pair goes in whole or not at all
      if (QUEUE_DEPTH - 1 - used >= 2) begin
        slot_mem[wr_slot].report_modifier = req.modifier;
        slot_mem[wr_slot].report_keycode  = req.keycode;
        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
        slot_mem[wr_slot] = '0;
        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
      end
    end else begin
      hold = long_pause_armed ? TIME_W'(pause_len) : '0;
      // elapsed time wraps modulo 2^64
      if (rd_slot != wr_slot && (req.time_us - last_report_time) >= hold) begin
        head = slot_mem[rd_slot];
        rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
        long_pause_armed = (head.report_keycode == KEY_ENTER) ||
                           (head.report_modifier == MOD_LEFT_GUI &&
                            head.report_keycode == KEY_R);
        last_report_time = req.time_us;
        due_reports.push_back(head);
      end
    end
  endtask

  // Compare one accepted report with the oldest one due
  task automatic check_report(input report_t got);
    report_t want;
    if (due_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("unexpected report: mod %02h key %02h",
                 got.report_modifier, got.report_keycode);
    end else begin
      want = due_reports.pop_front();
      if (got.report_modifier !== want.report_modifier ||
          got.report_keycode !== want.report_keycode) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("report mismatch: expected mod %02h key %02h, got mod %02h key %02h",
                   want.report_modifier, want.report_keycode,
                   got.report_modifier, got.report_keycode);
      end
    end
  endtask

  // Sample all ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      rd_slot          = 0;
      wr_slot          = 0;
      last_report_time = '0;
      long_pause_armed = 1'b0;
      pause_len        = LONG_DELAY_RESET;
      fail_count       = 0;
      due_reports.delete();
    end else begin
      if (long_delay_we)
        pause_len = long_delay_wdata;
      if (item_valid && !item_stall)
        pace_request(item);
      if (report_valid && !report_stall)
        check_report(report);
    end
    pending = due_reports.size();
  end

endmodule

// ----- dv/tb_keystroke_report_pacing_queue_top.sv -----
// ----------------------------------------------------------------------------
// tb_keystroke_report_pacing_queue_top
// Drives the pacing queue with a directed opening (empty queue, pause edges,
// time wrap, Enter and GUI+R triggers), then random phases of key pushes and
// time requests under several pause lengths, with random gaps and stalls.
// The checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------

module tb_keystroke_report_pacing_queue_top;
  import kprq_pkg::*;

  localparam int QUEUE_DEPTH   = 64;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 16;

  logic               clk;
  logic               rst;
  logic               long_delay_we;
  logic [DELAY_W-1:0] long_delay_wdata;
  logic               item_valid;
  logic               item_stall;
  item_t              item;
  logic               report_valid;
  logic               report_stall;
  report_t            report;

  int                 fail_count;
  int                 pending;
  bit                 idle_en;
  logic [TIME_W-1:0]  now_us;
  logic [DELAY_W-1:0] cur_delay;

  keystroke_report_pacing_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .long_delay_we    (long_delay_we),
    .long_delay_wdata (long_delay_wdata),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .report_valid     (report_valid),
    .report_stall     (report_stall),
    .report           (report)
  );

  kprq_report_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk              (clk),
    .rst              (rst),
    .long_delay_we    (long_delay_we),
    .long_delay_wdata (long_delay_wdata),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .report_valid     (report_valid),
    .report_stall     (report_stall),
    .report           (report),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Report side: random stall before each report, none when idling is off
  initial begin
    int gap;
    report_stall = 1'b0;
    forever begin
      gap = idle_en ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        report_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      report_stall <= 1'b0;
      do @(posedge clk); while (!report_valid);
      @(negedge clk);
    end
  end

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_request(input item_t req);
    int gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Key push; its time field is ignored, so fill it with noise
  task automatic send_key(input logic [7:0] mdf, input logic [7:0] kc);
    item_t req;
    req.kind     = KIND_PUSH;
    req.modifier = mdf;
    req.keycode  = kc;
    req.time_us  = {$urandom, $urandom};
    send_request(req);
  endtask

  // Time request; key fields are ignored
  task automatic send_tick(input logic [TIME_W-1:0] t);
    item_t req;
    req.kind     = KIND_TICK;
    req.modifier = $urandom;
    req.keycode  = $urandom;
    req.time_us  = t;
    send_request(req);
  endtask

  // Random key, weighted toward the pause triggers and their near misses
  task automatic random_key();
    int         pick;
    logic [7:0] mdf;
    logic [7:0] kc;
    pick = $urandom_range(0, 99);
    mdf  = $urandom;
    kc   = $urandom;
    if (pick < 20) begin
      kc = KEY_ENTER;
    end else if (pick < 35) begin
      mdf = MOD_LEFT_GUI;
      kc  = KEY_R;
    end else if (pick < 45) begin
      mdf = MOD_LEFT_GUI;
    end else if (pick < 55) begin
      kc = KEY_R;
    end
    send_key(mdf, kc);
  endtask

  // Random time step, sized against the current pause
  task automatic random_tick();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      now_us = now_us + $urandom_range(0, 3);
    end else if (pick < 70) begin
      now_us = now_us + $urandom_range(0, cur_delay / 2 + 1);
    end else if (pick < 90) begin
      // lands around the pause boundary
      now_us = now_us + cur_delay + $urandom_range(0, 2) - 1;
    end else if (pick < 95) begin
      now_us = {$urandom, $urandom};
    end else begin
      now_us = '1 - $urandom_range(0, 7);
    end
    send_tick(now_us);
  endtask

  // Hold off until every report is in and the block has settled
  task automatic drain();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] v);
    long_delay_we    <= 1'b1;
    long_delay_wdata <= v;
    @(negedge clk);
    long_delay_we    <= 1'b0;
    cur_delay = v;
  endtask

  // Stimulus and verdict
  initial begin
    int                 phase;
    int                 count;
    int                 burst;
    int                 pick;
    logic [DELAY_W-1:0] phase_delay [NUM_PHASES];

    rst              = 1'b1;
    long_delay_we    = 1'b0;
    long_delay_wdata = '0;
    item_valid       = 1'b0;
    item             = '0;
    idle_en          = 1'b1;
    now_us           = '0;
    cur_delay        = LONG_DELAY_RESET;

    phase_delay[0] = 20'd0;
    phase_delay[1] = 20'd1000000;
    phase_delay[2] = 20'd1;
    phase_delay[3] = LONG_DELAY_RESET;
    phase_delay[4] = DELAY_W'($urandom_range(2, 2000));
    phase_delay[5] = 20'd1000000;
    phase_delay[6] = DELAY_W'($urandom_range(0, 1000000));
    phase_delay[7] = 20'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening, pause at its reset value
    send_tick(64'd5);                       // empty queue
    send_key(8'hFF, 8'hFF);
    send_key(8'h00, 8'h00);
    send_key(MOD_LEFT_GUI, KEY_R);
    send_key(8'h00, KEY_ENTER);
    send_key(MOD_LEFT_GUI, 8'h16);          // GUI without R
    send_key(8'h0A, KEY_R);                 // R with extra modifier bits
    send_tick(64'd0);
    send_tick(64'd0);
    send_tick(64'd0);
    send_tick(64'd0);
    send_tick(64'd1);                       // GUI+R arms the pause
    send_tick(64'd150000);                  // one short of the pause
    send_tick(64'd150001);                  // exactly the pause
    send_tick(64'd150001);                  // Enter arms the pause
    send_tick(64'd150000);                  // time went back: wraps to huge
    send_tick('1);
    send_tick('1);
    send_tick('1);
    send_tick('1);
    send_tick('1);                          // empty again
    drain();

    // Random phases, each under its own pause length
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_delay(phase_delay[phase]);
      idle_en = (phase != 2) && (phase != 5);
      count   = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // burst of pushes, can run the queue into its full limit
          burst = $urandom_range(20, 35);
          repeat (burst) random_key();
          count += burst;
        end else if (pick < 38) begin
          random_key();
          count++;
        end else begin
          random_tick();
          count++;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/kprq_pkg.sv
hw/rtl/kprq_front.sv
hw/rtl/kprq_back.sv
hw/rtl/keystroke_report_pacing_queue_top.sv
hw/rtl/kprq_checker.sv
dv/kprq_report_checker.sv
dv/tb_keystroke_report_pacing_queue_top.sv
